FILE: rtl/ppu_pixel_priority_composer_macros.svh
// Assertion macros shared by the pixel composer RTL.
`ifndef PPU_PIXEL_PRIORITY_COMPOSER_MACROS_SVH
`define PPU_PIXEL_PRIORITY_COMPOSER_MACROS_SVH

`ifndef ASSERT_OFF
`define PPC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("ppc assertion failed");
`define PPC_ASSERT_NEVER(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
    else $error("ppc forbidden condition seen");
`else
`define PPC_ASSERT(lbl, prop)
`define PPC_ASSERT_NEVER(lbl, cond)
`endif

`endif

FILE: rtl/ppc_pkg.sv
// Shared types and constants of the pixel priority composer.
package ppc_pkg;

  localparam int SPRITE_SLOTS = 16;
  localparam int CNT_W        = $clog2(SPRITE_SLOTS + 1);

  localparam logic [1:0] OP_PAL_WR = 2'd0;
  localparam logic [1:0] OP_CLEAR  = 2'd1;
  localparam logic [1:0] OP_APPEND = 2'd2;
  localparam logic [1:0] OP_PIXEL  = 2'd3;

  localparam logic [1:0] SRC_OVERLAY  = 2'd0;
  localparam logic [1:0] SRC_SPRITE   = 2'd1;
  localparam logic [1:0] SRC_BG       = 2'd2;
  localparam logic [1:0] SRC_BACKDROP = 2'd3;

  localparam logic [2:0] REG_COLOR_MOD    = 3'd0;
  localparam logic [2:0] REG_OVL_BASE     = 3'd1;
  localparam logic [2:0] REG_SPR_BASES    = 3'd2;
  localparam logic [2:0] REG_BG_BASES     = 3'd3;
  localparam logic [2:0] REG_BG_FG_INFO   = 3'd4;
  localparam logic [2:0] REG_DISP_ENABLES = 3'd5;

  typedef struct packed {
    logic [7:0]  x;
    logic [23:0] planes;
    logic [2:0]  pal;
    logic        fg;
  } spr_t;

  typedef struct packed {
    logic       vld;
    logic [7:0] col;
    logic       found;
    logic [2:0] c;
    logic [2:0] pal;
    logic       fg;
  } tok_t;

  typedef struct packed {
    logic clear;
    logic append;
  } chain_ctl_t;

endpackage

FILE: rtl/ppc_sprite_cell.sv
// One sprite slot: holds a sprite and tests a passing pixel query against it.
module ppc_sprite_cell
  import ppc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic wr_en,
  input  spr_t wr,
  input  logic active,
  input  tok_t tok_i,
  output tok_t tok_o
);

  spr_t       spr_r;
  tok_t       tok_r;
  tok_t       tok_nxt;
  logic [8:0] diff;
  logic [2:0] k;
  logic       hit;
  logic [2:0] c;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      spr_r <= wr;
    end
  end

  always_comb begin
    diff = {1'b0, tok_i.col} - {1'b0, spr_r.x};
    k    = diff[2:0];
    hit  = !diff[8] && (diff[7:3] == 5'd0);
    c    = {spr_r.planes[16 + k], spr_r.planes[8 + k], spr_r.planes[k]};
    tok_nxt = tok_i;
    if (active && !tok_i.found && hit && (c != 3'd0)) begin
      tok_nxt.found = 1'b1;
      tok_nxt.c     = c;
      tok_nxt.pal   = spr_r.pal;
      tok_nxt.fg    = spr_r.fg;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_nxt;
    end
  end

  assign tok_o = tok_r;

endmodule

FILE: rtl/ppc_sprite_chain.sv
// Row of sprite cells with the scanline sprite count and append logic.
`include "ppu_pixel_priority_composer_macros.svh"
module ppc_sprite_chain
  import ppc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  chain_ctl_t ctl,
  input  spr_t       wr,
  input  tok_t       tok_i,
  output tok_t       tok_o
);

  logic [CNT_W-1:0]        count_r;
  logic [CNT_W-1:0]        count_nxt;
  tok_t                    tok [SPRITE_SLOTS+1];
  logic [SPRITE_SLOTS-1:0] tok_vld;

  assign tok[0] = tok_i;

  for (genvar i = 0; i < SPRITE_SLOTS; i++) begin : g_cell
    ppc_sprite_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .wr_en  (ctl.append && (count_r == CNT_W'(i))),
      .wr     (wr),
      .active (count_r > CNT_W'(i)),
      .tok_i  (tok[i]),
      .tok_o  (tok[i+1])
    );
    assign tok_vld[i] = tok[i+1].vld;
  end

  always_comb begin
    count_nxt = count_r;
    if (ctl.clear) begin
      count_nxt = '0;
    end else if (ctl.append && (count_r < CNT_W'(SPRITE_SLOTS))) begin
      count_nxt = count_r + CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign tok_o = tok[SPRITE_SLOTS];

  `PPC_ASSERT(a_count_bound, count_r <= CNT_W'(SPRITE_SLOTS))
  `PPC_ASSERT(a_single_query, $onehot0(tok_vld))

endmodule

FILE: rtl/ppu_pixel_priority_composer.sv
// Top level of the pixel priority composer. Palette writes, clears and appends act on acceptance.
// A pixel transaction passes one register per sprite cell, starting at the accepting edge,
// then the palette RAM read register, then the add into the output register.
// The next transaction is accepted once the current pixel reaches the output register, so
// a new pixel is never taken before the last one is through; output stalls delay it further.
// Synchronous active-low reset clears control state and sets the config registers to defaults.
`include "ppu_pixel_priority_composer_macros.svh"
module ppu_pixel_priority_composer
  import ppc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_opcode,
  input  logic [7:0]  in_palette_index,
  input  logic [7:0]  in_palette_value,
  input  logic [7:0]  in_column,
  input  logic [23:0] in_sprite_planes,
  input  logic [2:0]  in_sprite_palette,
  input  logic        in_sprite_foreground,
  input  logic [1:0]  in_bg_raw_color,
  input  logic [1:0]  in_bg_palette,
  input  logic [1:0]  in_screen,
  input  logic [1:0]  in_overlay_color,
  input  logic        in_overlay_attr_bit,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_pixel_color,
  output logic [1:0]  out_pixel_source,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CHAIN = 2'd1;
  localparam logic [1:0] ST_DATA  = 2'd2;

  logic [1:0]  state_r, state_nxt;
  logic [7:0]  color_mod_r;
  logic [4:0]  ovl_base_r;
  logic [7:0]  spr_bases_r;
  logic [15:0] bg_bases_r;
  logic [31:0] bg_fg_info_r;
  logic [2:0]  disp_en_r;

  logic [1:0]  raw_r, bpal_r, scr_r, ov_r;
  logic        oattr_r;

  logic [7:0]  pal_mem [256];
  logic [7:0]  rd_data_r;
  logic        use_mod_r;
  logic [1:0]  src_r;

  logic        out_valid_r;
  logic [7:0]  out_color_r;
  logic [1:0]  out_src_r;

  logic        accept;
  logic        pix_acc;
  chain_ctl_t  ctl;
  spr_t        wr_spr;
  tok_t        tok_in, tok_out;

  logic [1:0]  fgcnt;
  logic [2:0]  nback;
  logic        bg_prio;
  logic [7:0]  rd_addr;
  logic [1:0]  src;
  logic        use_mod;
  logic        out_free;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;
  assign pix_acc  = accept && (in_opcode == OP_PIXEL);
  assign out_free = !out_valid_r || out_ready;

  assign ctl.clear  = accept && (in_opcode == OP_CLEAR);
  assign ctl.append = accept && (in_opcode == OP_APPEND);
  assign wr_spr.x      = in_column;
  assign wr_spr.planes = in_sprite_planes;
  assign wr_spr.pal    = in_sprite_palette;
  assign wr_spr.fg     = in_sprite_foreground;

  always_comb begin
    tok_in       = '0;
    tok_in.vld   = pix_acc;
    tok_in.col   = in_column;
  end

  ppc_sprite_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (ctl),
    .wr    (wr_spr),
    .tok_i (tok_in),
    .tok_o (tok_out)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      color_mod_r  <= '0;
      ovl_base_r   <= '0;
      spr_bases_r  <= '0;
      bg_bases_r   <= '0;
      bg_fg_info_r <= '0;
      disp_en_r    <= 3'b111;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOR_MOD:    color_mod_r  <= cfg_data[7:0];
        REG_OVL_BASE:     ovl_base_r   <= cfg_data[4:0];
        REG_SPR_BASES:    spr_bases_r  <= cfg_data[7:0];
        REG_BG_BASES:     bg_bases_r   <= cfg_data[15:0];
        REG_BG_FG_INFO:   bg_fg_info_r <= cfg_data;
        REG_DISP_ENABLES: disp_en_r    <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (pix_acc) begin
      raw_r   <= in_bg_raw_color;
      bpal_r  <= in_bg_palette;
      scr_r   <= in_screen;
      ov_r    <= in_overlay_color;
      oattr_r <= in_overlay_attr_bit;
    end
  end

  always_comb begin
    fgcnt = bg_fg_info_r[{scr_r, bpal_r, 1'b0} +: 2];
    nback = 3'd4 - {1'b0, fgcnt};
    if (nback != 3'd4) begin
      nback = nback - 3'd1;
    end
    bg_prio = {1'b0, raw_r} >= nback;

    if ((ov_r != 2'd0) && disp_en_r[0]) begin
      rd_addr = {ovl_base_r, oattr_r, ov_r};
      src     = SRC_OVERLAY;
      use_mod = 1'b1;
    end else if (tok_out.found && (tok_out.fg || !bg_prio) && disp_en_r[1]) begin
      rd_addr = {spr_bases_r[{scr_r, 1'b0} +: 2], tok_out.pal, tok_out.c};
      src     = SRC_SPRITE;
      use_mod = 1'b1;
    end else if (disp_en_r[2]) begin
      rd_addr = {bg_bases_r[{scr_r, 2'b00} +: 4], bpal_r, raw_r};
      src     = SRC_BG;
      use_mod = 1'b1;
    end else begin
      rd_addr = color_mod_r;
      src     = SRC_BACKDROP;
      use_mod = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && (in_opcode == OP_PAL_WR)) begin
      pal_mem[in_palette_index] <= in_palette_value;
    end
    if ((state_r == ST_CHAIN) && tok_out.vld) begin
      rd_data_r <= pal_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_CHAIN) && tok_out.vld) begin
      src_r     <= src;
      use_mod_r <= use_mod;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE:  if (pix_acc) state_nxt = ST_CHAIN;
      ST_CHAIN: if (tok_out.vld) state_nxt = ST_DATA;
      ST_DATA:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == ST_DATA) && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == ST_DATA) && out_free) begin
      out_color_r <= rd_data_r + (use_mod_r ? color_mod_r : 8'd0);
      out_src_r   <= src_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_pixel_color  = out_color_r;
  assign out_pixel_source = out_src_r;

  `PPC_ASSERT(a_chain_exit_in_wait, tok_out.vld |-> (state_r == ST_CHAIN))
  `PPC_ASSERT(a_result_loaded, (state_r == ST_DATA && out_free) |=> out_valid_r)
  `PPC_ASSERT_NEVER(a_no_query_outside_idle, tok_in.vld && (state_r != ST_IDLE))

endmodule
